[sv/radial_gradient_shader_unit_defines.svh]
// ----------------------------------------------------------------------------
// Radial gradient shader assertion macros
// Shared helpers for the concurrent checks of the shader modules.
// ----------------------------------------------------------------------------
`ifndef RADIAL_GRADIENT_SHADER_UNIT_DEFINES_SVH
`define RADIAL_GRADIENT_SHADER_UNIT_DEFINES_SVH

// Check a condition in the same cycle as its trigger
`define RGS_ASSERT_IMP(lbl, trig, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |-> (prop)) \
      else $error(msg);

// Check a condition in the cycle after its trigger
`define RGS_ASSERT_NXT(lbl, trig, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (prop)) \
      else $error(msg);

`endif

[sv/rgs_pkg.sv]
// ----------------------------------------------------------------------------
// Radial gradient shader package
// Constants, item and configuration types, and the stop color transform.
// ----------------------------------------------------------------------------
package rgs_pkg;

   localparam int IMAGE_SIZE = 256;
   localparam int MAX_STOPS  = 16;
   localparam int HALF       = IMAGE_SIZE / 2;
   // radius in units of 1/10000 pixel: (IMAGE_SIZE/2 - 1.0001) * 10000
   localparam int RK         = HALF * 10000 - 10001;
   localparam int IDX_W      = 4;
   localparam int ROOT_W     = 24;
   localparam int QUOT_W     = 18;
   // g = (root * RECIP) >> RECIP_SH equals floor(root * 10000 / RK) for any 24-bit root
   localparam int RECIP_SH   = 45;
   localparam logic [38:0] RECIP = 39'(((64'd10000 << RECIP_SH) + 64'(RK) - 64'd1)
                                       / 64'(RK));
   localparam int NUM_W      = RECIP_SH + QUOT_W;
   localparam int PROD_W     = 41;
   localparam int CSR_IDX_W  = 3;
   localparam logic [23:0] VMAX = 24'hFF0000;
   localparam logic [16:0] G_ONE = 17'd65536;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_STOP_COUNT  = 3'd0,
      CSR_SPREAD_MODE = 3'd1,
      CSR_XF_ENABLE   = 3'd2,
      CSR_COLOR_MUL   = 3'd3,
      CSR_COLOR_ADD   = 3'd4
   } csr_index_type;

   typedef enum logic [1:0] {
      EXT_PAD     = 2'd0,
      EXT_REPEAT  = 2'd1,
      EXT_REFLECT = 2'd2,
      EXT_CLAMP   = 2'd3
   } spread_type;

   typedef struct packed {
      logic             pixel;
      logic [IDX_W-1:0] idx;
      logic [16:0]      offset;
      logic [31:0]      color;
      logic [16:0]      g;
      logic             pad_last;
   } item_type;

   typedef struct packed {
      logic [4:0]  stop_count;
      logic        xf_en;
      logic [63:0] mul;
      logic [63:0] add;
   } cfg_type;

   // One channel in 255-units with 16 fraction bits, transform applied
   function automatic logic [23:0] chan_val(input logic [7:0] u, input logic [15:0] m,
                                            input logic [15:0] a, input logic en);
      logic signed [25:0] sum;
      sum = 26'($signed({1'b0, u})) * 26'($signed(m)) + 26'($signed(a)) * 26'sd255;
      if (!en) begin
         return {u, 16'h0000};
      end else if (sum < 26'sd0) begin
         return 24'h000000;
      end else if (sum > 26'sd65280) begin
         return VMAX;
      end else begin
         return {sum[15:0], 8'h00};
      end
   endfunction

endpackage

[sv/rgs_front.sv]
// ----------------------------------------------------------------------------
// Radial gradient shader front end
// Accepts items, passes stop writes on and computes the spread gradient
// position of pixels with a bit-serial square root and a reciprocal multiply.
// ----------------------------------------------------------------------------
module rgs_front import rgs_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  logic             req_mode,
   input  logic [3:0]       req_stop_index,
   input  logic [16:0]      req_stop_offset,
   input  logic [31:0]      req_stop_color,
   input  logic [7:0]       req_pixel_x,
   input  logic [7:0]       req_pixel_y,
   input  logic [1:0]       spread_mode,
   output logic             push,
   output item_type         push_item,
   input  logic             full
);

   typedef enum logic [2:0] {
      F_IDLE, F_SQRT, F_MUL_LO, F_MUL_HI, F_SPREAD, F_PUSH
   } fstate_type;

   fstate_type           state_ff, state_in;
   item_type             item_ff, item_in;
   logic [47:0]          rad_ff, rad_in;
   logic [26:0]          rem_ff, rem_in;
   logic [ROOT_W-1:0]    root_ff, root_in;
   logic [4:0]           cnt_ff, cnt_in;
   logic [NUM_W-1:0]     num_ff, num_in;

   logic signed [8:0]    dx, dy;
   logic [17:0]          sx, sy;
   logic [15:0]          d2;
   logic [26:0]          rem_sh, trial;
   logic [43:0]          mul_lo;
   logic [42:0]          mul_hi;
   logic [16:0]          g_sat, g_sp;
   logic                 pad_hit;

   // squared distance from the image center
   assign dx = $signed({1'b0, req_pixel_x}) - 9'(HALF);
   assign dy = $signed({1'b0, req_pixel_y}) - 9'(HALF);
   assign sx = 18'($signed(18'(dx)) * $signed(18'(dx)));
   assign sy = 18'($signed(18'(dy)) * $signed(18'(dy)));
   assign d2 = 16'(sx + sy);

   assign rem_sh = {rem_ff[24:0], rad_ff[47:46]};
   assign trial  = {1'b0, root_ff, 2'b01};

   // scale the root by the radius reciprocal in two partial products
   assign mul_lo = 44'(root_ff) * 44'(RECIP[19:0]);
   assign mul_hi = 43'(root_ff) * 43'(RECIP[38:20]);
   assign g_sat  = num_ff[NUM_W-1] ? 17'h1FFFF : num_ff[RECIP_SH +: 17];

   // fold the position per spread mode
   always_comb begin
      pad_hit = 1'b0;
      g_sp    = g_sat;
      unique case (spread_type'(spread_mode))
         EXT_PAD:     pad_hit = (g_sat > G_ONE);
         EXT_REPEAT:  g_sp = {1'b0, g_sat[15:0]};
         EXT_REFLECT: g_sp = g_sat[16] ? G_ONE - {1'b0, g_sat[15:0]}
                                       : {1'b0, g_sat[15:0]};
         EXT_CLAMP:   g_sp = (g_sat > G_ONE) ? G_ONE : g_sat;
         default:     g_sp = g_sat;
      endcase
   end

   assign req_ready = (state_ff == F_IDLE);
   assign push      = (state_ff == F_PUSH) && !full;
   assign push_item = item_ff;

   // next-state logic
   always_comb begin
      state_in = state_ff;
      item_in  = item_ff;
      rad_in   = rad_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      cnt_in   = cnt_ff;
      num_in   = num_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (req_valid) begin
               item_in.pixel    = req_mode;
               item_in.idx      = req_stop_index;
               item_in.offset   = req_stop_offset;
               item_in.color    = req_stop_color;
               item_in.g        = '0;
               item_in.pad_last = 1'b0;
               rad_in           = {d2, 32'h0};
               rem_in           = '0;
               root_in          = '0;
               cnt_in           = '0;
               state_in         = req_mode ? F_SQRT : F_PUSH;
            end
         end
         F_SQRT: begin
            rad_in = {rad_ff[45:0], 2'b00};
            if (rem_sh >= trial) begin
               rem_in  = rem_sh - trial;
               root_in = {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               rem_in  = rem_sh;
               root_in = {root_ff[ROOT_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'(ROOT_W - 1)) begin
               state_in = F_MUL_LO;
            end
         end
         F_MUL_LO: begin
            num_in   = NUM_W'(mul_lo);
            state_in = F_MUL_HI;
         end
         F_MUL_HI: begin
            num_in   = num_ff + {mul_hi, 20'h00000};
            state_in = F_SPREAD;
         end
         F_SPREAD: begin
            item_in.g        = g_sp;
            item_in.pad_last = pad_hit;
            state_in         = F_PUSH;
         end
         F_PUSH: begin
            if (!full) begin
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   // hold state and datapath registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      item_ff <= item_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
      cnt_ff  <= cnt_in;
      num_ff  <= num_in;
   end

endmodule

[sv/rgs_fifo.sv]
// ----------------------------------------------------------------------------
// Radial gradient shader item queue
// Two-entry queue between the front end and the back end.
// ----------------------------------------------------------------------------
`include "radial_gradient_shader_unit_defines.svh"

module rgs_fifo import rgs_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     push,
   input  item_type push_item,
   output logic     full,
   input  logic     pop,
   output item_type pop_item,
   output logic     empty
);

   item_type   q_mem [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_item = q_mem[rd_ptr_ff];

   // advance pointers and occupancy
   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store pushed item
   always_ff @(posedge clock) begin
      if (push) begin
         q_mem[wr_ptr_ff] <= push_item;
      end
   end

   `RGS_ASSERT_IMP(a_fifo_count, 1'b1, count_ff <= 2'd2, "queue occupancy overflow")
   `RGS_ASSERT_IMP(a_fifo_pop, pop, !empty, "pop from empty queue")
   `RGS_ASSERT_NXT(a_fifo_push, push && !pop, !empty, "pushed item lost")

endmodule

[sv/rgs_back.sv]
// ----------------------------------------------------------------------------
// Radial gradient shader back end
// Owns the stop table, brackets the gradient position, transforms and
// interpolates the stop colors and drives the result register.
// ----------------------------------------------------------------------------
`include "radial_gradient_shader_unit_defines.svh"

module rgs_back import rgs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        empty,
   input  item_type    pop_item,
   output logic        pop,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_pixel_color
);

   typedef enum logic [3:0] {
      B_IDLE, B_SCAN, B_CHECK, B_READ0, B_READ1, B_GET1,
      B_XF0, B_XF1, B_MUL, B_DIV, B_DONE
   } bstate_type;

   bstate_type              state_ff, state_in;
   item_type                it_ff, it_in;
   logic [IDX_W-1:0]        i_ff, i_in, s0_ff, s0_in, s1_ff, s1_in;
   logic                    have0_ff, have0_in;
   logic [16:0]             o0_ff, o0_in, o1_ff, o1_in, den_ff, den_in;
   logic [31:0]             c0_ff, c0_in, c1_ff, c1_in;
   logic signed [17:0]      gd_ff, gd_in;
   logic [23:0]             v0_ff [4];
   logic [23:0]             v0_in [4];
   logic signed [24:0]      diff_ff [4];
   logic signed [24:0]      diff_in [4];
   logic [PROD_W-1:0]       dq_ff [4];
   logic [PROD_W-1:0]       dq_in [4];
   logic [16:0]             drem_ff [4];
   logic [16:0]             drem_in [4];
   logic [3:0]              neg_ff, neg_in;
   logic [1:0]              k_ff, k_in;
   logic [5:0]              cnt_ff, cnt_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [31:0]             color_ff, color_in;

   logic [16:0]             off_mem [MAX_STOPS];
   logic [31:0]             col_mem [MAX_STOPS];
   logic [16:0]             rd_off_ff;
   logic [31:0]             rd_col_ff;
   logic [IDX_W-1:0]        rd_addr;
   logic                    mem_we;

   logic [4:0]              nsat;
   logic [IDX_W-1:0]        nlast;
   logic                    hit;
   logic [24:0]             dneg;
   logic [23:0]             dmag;
   logic [16:0]             gmag;
   logic [17:0]             r_sh [4];
   logic signed [42:0]      sv [4];
   logic [31:0]             packed_out;

   // saturate the stop count
   always_comb begin
      if (cfg.stop_count == 5'd0) begin
         nsat = 5'd1;
      end else if (cfg.stop_count > 5'(MAX_STOPS)) begin
         nsat = 5'(MAX_STOPS);
      end else begin
         nsat = cfg.stop_count;
      end
   end
   assign nlast = IDX_W'(nsat - 5'd1);

   assign hit  = (it_ff.g >= rd_off_ff);
   assign dneg = -diff_ff[k_ff];
   assign dmag = diff_ff[k_ff][24] ? dneg[23:0] : diff_ff[k_ff][23:0];
   assign gmag = gd_ff[17] ? 17'(-gd_ff) : gd_ff[16:0];

   // divider step and final add for each channel lane
   always_comb begin
      for (int l = 0; l < 4; l++) begin
         r_sh[l] = {drem_ff[l], dq_ff[l][PROD_W-1]};
         sv[l]   = 43'($signed({1'b0, v0_ff[l]}))
                 + (neg_ff[l] ? -43'($signed({1'b0, dq_ff[l]}))
                              : 43'($signed({1'b0, dq_ff[l]})));
         if (sv[l] < 43'sd0) begin
            packed_out[8*l +: 8] = 8'h00;
         end else if (sv[l] > 43'($signed({1'b0, VMAX}))) begin
            packed_out[8*l +: 8] = VMAX[23:16];
         end else begin
            packed_out[8*l +: 8] = sv[l][23:16];
         end
      end
   end

   assign pop             = (state_ff == B_IDLE) && !empty;
   assign mem_we          = pop && !pop_item.pixel;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_pixel_color = color_ff;

   // next-state logic
   always_comb begin
      state_in     = state_ff;
      it_in        = it_ff;
      i_in         = i_ff;
      s0_in        = s0_ff;
      s1_in        = s1_ff;
      have0_in     = have0_ff;
      o0_in        = o0_ff;
      o1_in        = o1_ff;
      c0_in        = c0_ff;
      c1_in        = c1_ff;
      gd_in        = gd_ff;
      den_in       = den_ff;
      v0_in        = v0_ff;
      diff_in      = diff_ff;
      dq_in        = dq_ff;
      drem_in      = drem_ff;
      neg_in       = neg_ff;
      k_in         = k_ff;
      cnt_in       = cnt_ff;
      color_in     = color_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rd_addr      = '0;
      unique case (state_ff)
         B_IDLE: begin
            if (!empty && pop_item.pixel) begin
               it_in    = pop_item;
               s0_in    = pop_item.pad_last ? nlast : '0;
               s1_in    = nlast;
               i_in     = '0;
               have0_in = 1'b0;
               state_in = pop_item.pad_last ? B_READ0 : B_SCAN;
            end
         end
         B_SCAN: begin
            rd_addr  = i_ff;
            state_in = B_CHECK;
         end
         B_CHECK: begin
            // lower stop is the last one at or below g, upper the next above
            if (hit) begin
               s0_in    = i_ff;
               have0_in = 1'b1;
            end else if (have0_ff) begin
               s1_in = i_ff;
            end
            if ((!hit && have0_ff) || i_ff == nlast) begin
               state_in = B_READ0;
            end else begin
               i_in     = i_ff + 1'b1;
               state_in = B_SCAN;
            end
         end
         B_READ0: begin
            rd_addr  = s0_ff;
            state_in = B_READ1;
         end
         B_READ1: begin
            rd_addr  = s1_ff;
            o0_in    = rd_off_ff;
            c0_in    = rd_col_ff;
            state_in = B_GET1;
         end
         B_GET1: begin
            o1_in    = rd_off_ff;
            c1_in    = rd_col_ff;
            state_in = B_XF0;
         end
         B_XF0: begin
            for (int l = 0; l < 4; l++) begin
               v0_in[l] = chan_val(c0_ff[8*l +: 8], cfg.mul[16*l +: 16],
                                   cfg.add[16*l +: 16], cfg.xf_en);
            end
            gd_in    = $signed({1'b0, it_ff.g}) - $signed({1'b0, o0_ff});
            den_in   = (o1_ff > o0_ff) ? o1_ff - o0_ff : 17'd1;
            state_in = B_XF1;
         end
         B_XF1: begin
            for (int l = 0; l < 4; l++) begin
               diff_in[l] = $signed({1'b0, chan_val(c1_ff[8*l +: 8], cfg.mul[16*l +: 16],
                                                    cfg.add[16*l +: 16], cfg.xf_en)})
                          - $signed({1'b0, v0_ff[l]});
            end
            k_in     = '0;
            state_in = B_MUL;
         end
         B_MUL: begin
            // one channel product a cycle, on magnitudes
            dq_in[k_ff]   = PROD_W'(dmag) * PROD_W'(gmag);
            drem_in[k_ff] = '0;
            neg_in[k_ff]  = diff_ff[k_ff][24] ^ gd_ff[17];
            k_in          = k_ff + 2'd1;
            cnt_in        = '0;
            if (k_ff == 2'd3) begin
               state_in = B_DIV;
            end
         end
         B_DIV: begin
            for (int l = 0; l < 4; l++) begin
               if (r_sh[l] >= {1'b0, den_ff}) begin
                  drem_in[l] = 17'(r_sh[l] - {1'b0, den_ff});
                  dq_in[l]   = {dq_ff[l][PROD_W-2:0], 1'b1};
               end else begin
                  drem_in[l] = r_sh[l][16:0];
                  dq_in[l]   = {dq_ff[l][PROD_W-2:0], 1'b0};
               end
            end
            cnt_in = cnt_ff + 6'd1;
            if (cnt_ff == 6'(PROD_W - 1)) begin
               state_in = B_DONE;
            end
         end
         B_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               color_in     = packed_out;
               state_in     = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   // hold state, datapath and result registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      it_ff    <= it_in;
      i_ff     <= i_in;
      s0_ff    <= s0_in;
      s1_ff    <= s1_in;
      have0_ff <= have0_in;
      o0_ff    <= o0_in;
      o1_ff    <= o1_in;
      c0_ff    <= c0_in;
      c1_ff    <= c1_in;
      gd_ff    <= gd_in;
      den_ff   <= den_in;
      v0_ff    <= v0_in;
      diff_ff  <= diff_in;
      dq_ff    <= dq_in;
      drem_ff  <= drem_in;
      neg_ff   <= neg_in;
      k_ff     <= k_in;
      cnt_ff   <= cnt_in;
      color_ff <= color_in;
   end

   // stop table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         off_mem[pop_item.idx] <= pop_item.offset;
         col_mem[pop_item.idx] <= pop_item.color;
      end
      rd_off_ff <= off_mem[rd_addr];
      rd_col_ff <= col_mem[rd_addr];
   end

   `RGS_ASSERT_IMP(a_den_nonzero, state_ff == B_DIV, den_ff != 17'd0, "zero interpolation divisor")
   `RGS_ASSERT_IMP(a_scan_bound, state_ff == B_CHECK, i_ff <= nlast, "stop scan past last stop")
   `RGS_ASSERT_NXT(a_done_out, state_ff == B_DONE && (!rsp_valid_ff || rsp_ready), rsp_valid_ff && state_ff == B_IDLE, "finished pixel not presented")

endmodule

[sv/radial_gradient_shader_unit.sv]
// Path: a stop write passes the front end's item register and the queue; the back end
// writes it to the table on pop. A pixel passes the front end (24-step square root, two
// multiply steps), the queue and the back end (stop scan, 41-step divide). Throughput:
// front and back overlap through the queue, the back end's stop scan and divider set the
// pixel rate and a held result stalls the back end; each end works on one item at a time.
// Reset: synchronous; control state cleared, registers to defaults, stop table kept.
// ----------------------------------------------------------------------------
// Radial gradient shader unit
// Top level: configuration registers, front end, item queue and back end.
// ----------------------------------------------------------------------------
module radial_gradient_shader_unit import rgs_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic                 req_mode,
   input  logic [3:0]           req_stop_index,
   input  logic [16:0]          req_stop_offset,
   input  logic [31:0]          req_stop_color,
   input  logic [7:0]           req_pixel_x,
   input  logic [7:0]           req_pixel_y,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [31:0]          rsp_pixel_color,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]          csr_wdata
);

   logic [4:0]  stop_count_ff, stop_count_in;
   logic [1:0]  spread_ff, spread_in;
   logic        xf_ff, xf_in;
   logic [63:0] mul_ff, mul_in, add_ff, add_in;
   cfg_type     cfg;
   logic        push, pop, full, empty;
   item_type    push_item, pop_item;
   logic        csr_we;

   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid && csr_ready;

   // decode register writes
   always_comb begin
      stop_count_in = stop_count_ff;
      spread_in     = spread_ff;
      xf_in         = xf_ff;
      mul_in        = mul_ff;
      add_in        = add_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_STOP_COUNT:  stop_count_in = csr_wdata[4:0];
            CSR_SPREAD_MODE: spread_in     = csr_wdata[1:0];
            CSR_XF_ENABLE:   xf_in         = csr_wdata[0];
            CSR_COLOR_MUL:   mul_in        = csr_wdata;
            CSR_COLOR_ADD:   add_in        = csr_wdata;
            default:         stop_count_in = stop_count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stop_count_ff <= 5'd2;
         spread_ff     <= EXT_PAD;
         xf_ff         <= 1'b0;
         mul_ff        <= 64'h0100_0100_0100_0100;
         add_ff        <= 64'h0;
      end else begin
         stop_count_ff <= stop_count_in;
         spread_ff     <= spread_in;
         xf_ff         <= xf_in;
         mul_ff        <= mul_in;
         add_ff        <= add_in;
      end
   end

   assign cfg.stop_count = stop_count_ff;
   assign cfg.xf_en      = xf_ff;
   assign cfg.mul        = mul_ff;
   assign cfg.add        = add_ff;

   rgs_front u_front (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_mode        (req_mode),
      .req_stop_index  (req_stop_index),
      .req_stop_offset (req_stop_offset),
      .req_stop_color  (req_stop_color),
      .req_pixel_x     (req_pixel_x),
      .req_pixel_y     (req_pixel_y),
      .spread_mode     (spread_ff),
      .push            (push),
      .push_item       (push_item),
      .full            (full)
   );

   rgs_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .full      (full),
      .pop       (pop),
      .pop_item  (pop_item),
      .empty     (empty)
   );

   rgs_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .empty           (empty),
      .pop_item        (pop_item),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_pixel_color (rsp_pixel_color)
   );

endmodule

[sim/rgs_result_checker.sv]
// ----------------------------------------------------------------------------
// Radial gradient shader result checker
// Watches the request, result and register channels, predicts each pixel
// color from its own copy of the stop table and registers, and compares.
// ----------------------------------------------------------------------------
module rgs_result_checker import rgs_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_ready,
   input  logic                 req_mode,
   input  logic [3:0]           req_stop_index,
   input  logic [16:0]          req_stop_offset,
   input  logic [31:0]          req_stop_color,
   input  logic [7:0]           req_pixel_x,
   input  logic [7:0]           req_pixel_y,
   input  logic                 rsp_valid,
   input  logic                 rsp_ready,
   input  logic [31:0]          rsp_pixel_color,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]          csr_wdata,
   output int                   fail_count,
   output int                   pending_count
);

   localparam longint COLOR_MAX = 255 * 65536;

   // shadow registers and stop table
   logic [4:0]  count_reg;
   spread_type  spread_reg;
   logic        xf_reg;
   logic [63:0] mul_reg;
   logic [63:0] add_reg;
   logic [16:0] offset_tbl [MAX_STOPS];
   logic [31:0] color_tbl [MAX_STOPS];
   logic [31:0] expected_colors [$];

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      fail_count++;
   endtask

   function automatic longint unsigned int_sqrt(input longint unsigned v);
      longint unsigned r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b = b >> 2;
      while (b != 0) begin
         if (v >= r + b) begin
            v = v - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   function automatic longint clamp_chan(input longint v);
      return v < 0 ? 0 : (v > COLOR_MAX ? COLOR_MAX : v);
   endfunction

   // one channel in 255-units with 16 fraction bits, transform applied
   function automatic longint stop_chan(input logic [31:0] c, input int k);
      longint u, m, a;
      u = longint'(c[8*k +: 8]);
      if (!xf_reg) return u * 65536;
      m = longint'($signed(mul_reg[16*k +: 16]));
      a = longint'($signed(add_reg[16*k +: 16]));
      return clamp_chan((u * m + a * 255) * 256);
   endfunction

   function automatic logic [31:0] last_stop_color(input int n);
      logic [31:0] res;
      res = '0;
      for (int k = 0; k < 4; k++) res[8*k +: 8] = 8'(stop_chan(color_tbl[n-1], k) >> 16);
      return res;
   endfunction

   // bracket g between two stops and interpolate each channel
   function automatic logic [31:0] blend_stops(input longint g, input int n);
      int s0, s1;
      bit have0, have1;
      longint o0, o1, den, v0, v1;
      logic [31:0] res;
      s0 = 0; s1 = 0; have0 = 0; have1 = 0; res = '0;
      for (int i = 0; i < n && !have1; i++) begin
         if (g >= longint'(offset_tbl[i])) begin
            s0 = i;
            have0 = 1;
         end else if (have0) begin
            s1 = i;
            have1 = 1;
         end
      end
      if (!have1) s1 = n - 1;
      o0 = longint'(offset_tbl[s0]);
      o1 = longint'(offset_tbl[s1]);
      den = (o1 - o0 < 1) ? 1 : o1 - o0;
      for (int k = 0; k < 4; k++) begin
         v0 = stop_chan(color_tbl[s0], k);
         v1 = stop_chan(color_tbl[s1], k);
         res[8*k +: 8] = 8'(clamp_chan(v0 + ((v1 - v0) * (g - o0)) / den) >> 16);
      end
      return res;
   endfunction

   function automatic logic [31:0] shade_pixel(input logic [7:0] x, input logic [7:0] y);
      longint dx, dy, g;
      longint unsigned root;
      int n;
      n = (count_reg < 1) ? 1 : (count_reg > MAX_STOPS ? MAX_STOPS : int'(count_reg));
      dx = longint'(x) - HALF;
      dy = longint'(y) - HALF;
      root = int_sqrt(longint'(dx * dx + dy * dy) << 32);
      g = longint'(root * 10000 / RK);
      if (g > 131071) g = 131071;
      if (spread_reg == EXT_PAD) begin
         if (g > 65536) return last_stop_color(n);
         return blend_stops(g, n);
      end
      if (spread_reg == EXT_REPEAT) g = g & 65535;
      else if (spread_reg == EXT_REFLECT) g = g[16] ? 65536 - (g & 65535) : g & 65535;
      if (g > 65536) g = 65536;
      return blend_stops(g, n);
   endfunction

   // track registers, table writes, pixels and results
   always @(posedge clock) begin
      if (reset) begin
         count_reg <= 5'd2;
         spread_reg <= EXT_PAD;
         xf_reg <= 1'b0;
         mul_reg <= 64'h0100010001000100;
         add_reg <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_STOP_COUNT: count_reg <= csr_wdata[4:0];
               CSR_SPREAD_MODE: spread_reg <= spread_type'(csr_wdata[1:0]);
               CSR_XF_ENABLE: xf_reg <= csr_wdata[0];
               CSR_COLOR_MUL: mul_reg <= csr_wdata;
               CSR_COLOR_ADD: add_reg <= csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            if (!req_mode) begin
               offset_tbl[req_stop_index] = req_stop_offset;
               color_tbl[req_stop_index] = req_stop_color;
            end else begin
               expected_colors.push_back(shade_pixel(req_pixel_x, req_pixel_y));
            end
         end
         if (rsp_valid && rsp_ready) begin
            if (expected_colors.size() == 0) begin
               report_mismatch($sformatf("unexpected result %h", rsp_pixel_color));
            end else begin
               if (rsp_pixel_color !== expected_colors[0])
                  report_mismatch($sformatf("pixel_color %h, expected %h",
                                            rsp_pixel_color, expected_colors[0]));
               void'(expected_colors.pop_front());
            end
         end
      end
      pending_count <= expected_colors.size();
   end

   initial fail_count = 0;

endmodule

[sim/tb_radial_gradient_shader_unit.sv]
// ----------------------------------------------------------------------------
// Radial gradient shader unit testbench
// Loads stop tables, sweeps register settings and drives pixels under random
// flow control; the checker beside the block predicts and compares colors.
// ----------------------------------------------------------------------------
module tb_radial_gradient_shader_unit import rgs_pkg::*;;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_ready;
   logic                 req_mode;
   logic [3:0]           req_stop_index;
   logic [16:0]          req_stop_offset;
   logic [31:0]          req_stop_color;
   logic [7:0]           req_pixel_x;
   logic [7:0]           req_pixel_y;
   logic                 rsp_valid;
   logic                 rsp_ready;
   logic [31:0]          rsp_pixel_color;
   logic                 csr_valid;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [63:0]          csr_wdata;
   int                   fail_count;
   int                   pending_count;
   bit                   idle_on;
   bit                   hold_request;

   radial_gradient_shader_unit dut (.*);

   rgs_result_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #20000000;
      $display("CHECKS FAILED");
      $finish;
   end

   // gap length: mostly short, a few long
   function automatic int gap_len();
      if (!idle_on || $urandom_range(0, 2) == 0) return 0;
      return ($urandom_range(0, 19) == 0) ? $urandom_range(10, 60) : $urandom_range(1, 3);
   endfunction

   // result side stalls, with one long hold on request
   initial begin
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (hold_request) begin
            rsp_ready <= 1'b0;
            for (int c = 0; c < 600; c++) @(posedge clock);
            hold_request = 0;
         end
         rsp_ready <= !(idle_on && $urandom_range(0, 3) == 0);
      end
   end

   task automatic send_item(input logic mode, input logic [3:0] idx, input logic [16:0] off,
                            input logic [31:0] col, input logic [7:0] x, input logic [7:0] y);
      int g;
      g = gap_len();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_stop_index <= idx;
      req_stop_offset <= off;
      req_stop_color <= col;
      req_pixel_x <= x;
      req_pixel_y <= y;
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_pixel(input logic [7:0] x, input logic [7:0] y);
      send_item(1'b1, 4'($urandom), 17'($urandom), $urandom, x, y);
   endtask

   task automatic send_stop(input logic [3:0] idx, input logic [16:0] off, input logic [31:0] col);
      send_item(1'b0, idx, off, col, 8'($urandom), 8'($urandom));
   endtask

   // drop valid, drain all results, then let stop writes settle
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
      repeat (100) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [63:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // write all stops with non-decreasing random offsets
   task automatic load_sorted_table();
      int o;
      o = 0;
      for (int i = 0; i < MAX_STOPS; i++) begin
         o = o + $urandom_range(0, 9000);
         if (o > 65536) o = 65536;
         send_stop(4'(i), 17'(o), $urandom);
      end
   endtask

   function automatic logic [63:0] rand_lanes();
      logic [63:0] v;
      v = {$urandom, $urandom};
      case ($urandom_range(0, 4))
         0: v = '0;
         1: v = '1;
         2: v = 64'h7FFF7FFF7FFF7FFF;
         3: v = 64'h8000800080008000;
         default: ;
      endcase
      return v;
   endfunction

   initial begin
      logic [4:0] cnt;
      reset = 1'b1;
      req_valid = 1'b0;
      req_mode = 1'b0;
      req_stop_index = '0;
      req_stop_offset = '0;
      req_stop_color = '0;
      req_pixel_x = '0;
      req_pixel_y = '0;
      csr_valid = 1'b0;
      csr_index = CSR_STOP_COUNT;
      csr_wdata = '0;
      idle_on = 1'b0;
      hold_request = 0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: full table with extreme offsets and colors
      for (int i = 0; i < MAX_STOPS; i++)
         send_stop(4'(i), (i == 0) ? 17'd0 : (i >= 12 ? 17'd65536 : 17'(i * 5000)),
                   (i % 2) ? 32'hFFFFFFFF : 32'h00000000);
      send_pixel(8'd128, 8'd128);
      send_pixel(8'd0, 8'd0);
      drain();
      write_reg(CSR_STOP_COUNT, 64'd16);
      write_reg(CSR_XF_ENABLE, 64'd1);
      write_reg(CSR_COLOR_MUL, 64'h8000_7FFF_0100_FF00);
      write_reg(CSR_COLOR_ADD, 64'h0100_FF00_0080_0000);
      send_pixel(8'd128, 8'd128);
      send_pixel(8'd255, 8'd255);
      send_pixel(8'd128, 8'd0);
      send_pixel(8'd0, 8'd128);
      send_pixel(8'd200, 8'd140);
      drain();
      write_reg(CSR_SPREAD_MODE, 64'(EXT_REPEAT));
      send_pixel(8'd0, 8'd0);
      send_pixel(8'd10, 8'd240);
      drain();
      write_reg(CSR_SPREAD_MODE, 64'(EXT_REFLECT));
      send_pixel(8'd0, 8'd0);
      send_pixel(8'd10, 8'd240);
      drain();
      write_reg(CSR_SPREAD_MODE, 64'(EXT_CLAMP));
      write_reg(CSR_STOP_COUNT, 64'd31);
      send_pixel(8'd0, 8'd0);
      send_pixel(8'd64, 8'd64);
      drain();

      // random phases over register settings
      for (int p = 0; p < 14; p++) begin
         idle_on = (p % 4) != 1;
         case (p)
            0: cnt = 5'd0;
            1: cnt = 5'd1;
            2: cnt = 5'd16;
            3: cnt = 5'd31;
            default: cnt = 5'($urandom_range(1, 16));
         endcase
         write_reg(CSR_STOP_COUNT, 64'(cnt));
         write_reg(CSR_SPREAD_MODE, 64'(p % 4));
         write_reg(CSR_XF_ENABLE, 64'($urandom_range(0, 1)));
         write_reg(CSR_COLOR_MUL, rand_lanes());
         write_reg(CSR_COLOR_ADD, rand_lanes());
         if ($urandom_range(0, 3) != 0) load_sorted_table();
         if (p == 5) hold_request = 1;
         for (int n = 0; n < 110; n++) begin
            if ($urandom_range(0, 9) == 0)
               send_stop(4'($urandom), ($urandom_range(0, 3) == 0) ? 17'd65536
                                       : 17'($urandom_range(0, 65535)), $urandom);
            else if ($urandom_range(0, 3) == 0)
               send_pixel(8'($urandom_range(96, 160)), 8'($urandom_range(96, 160)));
            else
               send_pixel(8'($urandom), 8'($urandom));
         end
         drain();
      end

      if (fail_count == 0 && pending_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

[filelist.f]
+incdir+sv
sv/rgs_pkg.sv
sv/rgs_front.sv
sv/rgs_fifo.sv
sv/rgs_back.sv
sv/radial_gradient_shader_unit.sv
sim/rgs_result_checker.sv
sim/tb_radial_gradient_shader_unit.sv
